FILE: rtl/skya_pkg.sv
// ----------------------------------------------------------------------------
// skya_pkg
// Shared types and constants of the skyline atlas allocator.
// ----------------------------------------------------------------------------
package skya_pkg;

	localparam int unsigned DEF_MAX_COLUMNS = 512;
	localparam int unsigned DEF_MAX_ROWS    = 512;

	localparam int unsigned DIM_W       = 10;  // block and page dimensions
	localparam int unsigned POS_W       = 9;   // reported left / top
	localparam int unsigned OFFSET_W    = 20;  // reported byte offset
	localparam int unsigned TEXEL_SHIFT = 2;   // four bytes per texel
	localparam int unsigned CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;

	localparam logic [DIM_W-1:0] RST_ATLAS_WIDTH  = 10'd512;
	localparam logic [DIM_W-1:0] RST_ATLAS_HEIGHT = 10'd512;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic             command;
		logic [DIM_W-1:0] block_width;
		logic [DIM_W-1:0] block_height;
	} req_item_t;

	typedef struct packed {
		logic                ok;
		logic [POS_W-1:0]    left;
		logic [POS_W-1:0]    top;
		logic [OFFSET_W-1:0] byte_offset;
	} rsp_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     value;
	} cfg_write_t;

endpackage

FILE: rtl/skya_stream_if.sv
// ----------------------------------------------------------------------------
// skya_stream_if
// Valid/ready channel; one transfer per clock when both are high.
// ----------------------------------------------------------------------------
interface skya_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/skyline_atlas_allocator.sv
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// Skyline rectangle packer for one atlas page, column heights kept in RAM.
// ----------------------------------------------------------------------------
// One request at a time. After reset the column memory is zeroed by a pass
// over all MAX_COLUMNS columns during which req.ready stays low (cfg writes
// still go). A clear request zeroes the columns the same way and then
// answers. An allocate request reads the column memory through its single
// read port, one column a cycle but for a pause at each window change: each
// candidate window is walked left to right, a column at or above the best
// top so far ends the window and the scan resumes just past that column, a
// fitting window restarts at the next start column. After the scan a
// decision step checks that a window was found and fits the page height,
// then the chosen columns are raised. A rejected request (zero size, block
// at least as wide as the page) is answered without a scan. The response
// sits in an output register, so the next request can be taken while it
// waits on rsp.ready. Page width and height are captured when a request is taken.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator #(
	parameter int unsigned MAX_COLUMNS = skya_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = skya_pkg::DEF_MAX_ROWS
) (
	input  logic           clk,
	input  logic           arst_n,
	skya_stream_if.sink    cfg,
	skya_stream_if.sink    req,
	skya_stream_if.source  rsp
);
	import skya_pkg::*;

	// address of the column RAM, and counts that reach the column total
	localparam int unsigned AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned CW  = $clog2(MAX_COLUMNS + 1);
	localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
	localparam int unsigned SW  = ((CW > DIM_W) ? CW : DIM_W) + 1;
	localparam int unsigned HSW = ((RW > DIM_W) ? RW : DIM_W) + 1;
	localparam int unsigned PW  = RW + CW;
	localparam int unsigned OW  = PW + 1;
	localparam int unsigned OFF_HI_W = OFFSET_W - TEXEL_SHIFT;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CLEAR  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_WRITE  = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] atlas_width_q;
	logic [DIM_W-1:0] atlas_height_q;
	logic [CW-1:0]    w_q;          // effective width of the current request
	logic [RW-1:0]    h_q;          // effective height of the current request
	logic [DIM_W-1:0] bw_q;
	logic [DIM_W-1:0] bh_q;
	logic [CW-1:0]    s_q;          // start column of the window under test
	logic [CW-1:0]    rd_ptr_q;     // next column to read
	logic             pend_s1;      // a read is in flight
	logic [CW-1:0]    col_s1;       // column of that read
	logic [RW-1:0]    rd_data_s1;
	logic [RW-1:0]    peak_q;
	logic [RW-1:0]    best_q;
	logic [CW-1:0]    pick_q;
	logic             found_q;
	logic [PW-1:0]    prod_q;
	logic [CW-1:0]    wr_ptr_q;
	logic [AW-1:0]    clr_ptr_q;
	logic             clr_rsp_q;    // clear came from a request, not reset
	logic             ok_q;
	logic             place_q;      // response carries a placement
	logic             rsp_valid_q;
	rsp_item_t        rsp_data_q;

	logic [RW-1:0]    col_mem [MAX_COLUMNS];

	logic [CW-1:0]    eff_w;
	logic [RW-1:0]    eff_h;
	logic             reject;
	logic [RW-1:0]    c_max;
	logic [SW-1:0]    win_end;
	logic             hit_fail;
	logic             hit_last;
	logic [CW-1:0]    next_start;
	logic             scan_end;
	logic             rd_issue;
	logic             fits_h;
	logic [RW-1:0]    new_h;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [RW-1:0]    mem_wd;
	logic             req_fire;
	logic             rsp_load;
	logic [OW-1:0]    off_sum;
	rsp_item_t        rsp_next;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= RST_ATLAS_WIDTH;
			atlas_height_q <= RST_ATLAS_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_ATLAS_WIDTH:  atlas_width_q  <= cfg.data.value;
				REG_ATLAS_HEIGHT: atlas_height_q <= cfg.data.value;
				default: ;      // unknown index: ignored
			endcase
		end
	end

	// registers saturate at the page limits
	assign eff_w = (32'(atlas_width_q) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(atlas_width_q);
	assign eff_h = (32'(atlas_height_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(atlas_height_q);

	assign reject = (req.data.block_width == '0) || (req.data.block_height == '0) ||
	                (SW'(req.data.block_width) >= SW'(eff_w));

	// ---------------- scan datapath ----------------
	// A window fails on the first column not strictly below the best top;
	// every start up to that column fails as well, so the scan jumps past it.
	always_comb begin
		c_max      = (rd_data_s1 > peak_q) ? rd_data_s1 : peak_q;
		win_end    = SW'(s_q) + SW'(bw_q) - SW'(1);
		hit_fail   = pend_s1 && (rd_data_s1 >= best_q);
		hit_last   = pend_s1 && !hit_fail && (SW'(col_s1) == win_end);
		next_start = hit_fail ? (col_s1 + CW'(1)) : (s_q + CW'(1));
		scan_end   = (SW'(next_start) + SW'(bw_q)) >= SW'(w_q);
		rd_issue   = (state_q == ST_SCAN) && !hit_fail && !hit_last;
		fits_h     = (HSW'(best_q) + HSW'(bh_q)) <= HSW'(h_q);
		new_h      = RW'(HSW'(best_q) + HSW'(bh_q));
	end

	// ---------------- column RAM ----------------
	assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign mem_wa = (state_q == ST_CLEAR) ? clr_ptr_q : wr_ptr_q[AW-1:0];
	assign mem_wd = (state_q == ST_CLEAR) ? '0 : new_h;

	always_ff @(posedge clk) begin
		if (mem_we)
			col_mem[mem_wa] <= mem_wd;
		if (rd_issue)
			rd_data_s1 <= col_mem[rd_ptr_q[AW-1:0]];
	end

	// ---------------- handshakes ----------------
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_load  = (state_q == ST_RESP) && (!rsp_valid_q || rsp.ready);

	assign off_sum = OW'(prod_q) + OW'(pick_q);

	always_comb begin
		rsp_next.ok          = ok_q;
		rsp_next.left        = place_q ? POS_W'(pick_q) : '0;
		rsp_next.top         = place_q ? POS_W'(best_q) : '0;
		rsp_next.byte_offset = place_q ? {OFF_HI_W'(off_sum), {TEXEL_SHIFT{1'b0}}} : '0;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_ptr_q   <= '0;
			clr_rsp_q   <= 1'b0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			ok_q        <= 1'b0;
			place_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						w_q     <= eff_w;
						h_q     <= eff_h;
						bw_q    <= req.data.block_width;
						bh_q    <= req.data.block_height;
						place_q <= 1'b0;
						if (req.data.command == CMD_CLEAR) begin
							clr_ptr_q <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= ST_CLEAR;
						end else if (reject) begin
							ok_q    <= 1'b0;
							state_q <= ST_RESP;
						end else begin
							s_q      <= '0;
							rd_ptr_q <= '0;
							best_q   <= eff_h;
							peak_q   <= '0;
							found_q  <= 1'b0;
							pend_s1  <= 1'b0;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_CLEAR: begin
					clr_ptr_q <= clr_ptr_q + AW'(1);
					if (clr_ptr_q == AW'(MAX_COLUMNS - 1)) begin
						if (clr_rsp_q) begin
							ok_q    <= 1'b1;
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					if (hit_fail || hit_last) begin
						if (hit_last) begin
							pick_q  <= s_q;
							best_q  <= c_max;
							found_q <= 1'b1;
						end
						s_q      <= next_start;
						rd_ptr_q <= next_start;
						peak_q   <= '0;
						pend_s1  <= 1'b0;
						if (scan_end)
							state_q <= ST_DECIDE;
					end else begin
						if (pend_s1)
							peak_q <= c_max;
						col_s1   <= rd_ptr_q;
						rd_ptr_q <= rd_ptr_q + CW'(1);
						pend_s1  <= 1'b1;
					end
				end
				ST_DECIDE: begin
					prod_q   <= PW'(best_q) * PW'(w_q);
					wr_ptr_q <= pick_q;
					if (found_q && fits_h) begin
						state_q <= ST_WRITE;
					end else begin
						ok_q    <= 1'b0;
						state_q <= ST_RESP;
					end
				end
				ST_WRITE: begin
					wr_ptr_q <= wr_ptr_q + CW'(1);
					if (SW'(wr_ptr_q) == (SW'(pick_q) + SW'(bw_q) - SW'(1))) begin
						ok_q    <= 1'b1;
						place_q <= 1'b1;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load)
			rsp_data_q <= rsp_next;
	end

`ifndef ASSERT_OFF
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request taken while a previous one is still in work");

	a_read_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (rd_ptr_q < w_q))
		else $error("column read beyond the effective page width");

	a_best_below_height: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && (state_q == ST_SCAN || state_q == ST_DECIDE)) |-> (best_q < h_q))
		else $error("chosen window top not below the page height");

	a_write_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> ((new_h <= h_q) && (wr_ptr_q < w_q)))
		else $error("column raised above the page or outside its width");
`endif

endmodule
